// File: rtl/multi_click_classifier_defines.svh
// Assertion macros for the multi-click classifier
`ifndef MULTI_CLICK_CLASSIFIER_DEFINES_SVH
`define MULTI_CLICK_CLASSIFIER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define MCC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define MCC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/mcc_pkg.sv
package mcc_pkg;

	localparam int NUM_BUTTONS = 3;
	// one history entry per button plus one for the encoder button
	localparam int NUM_ENT     = NUM_BUTTONS + 1;
	localparam int ENT_W       = $clog2(NUM_ENT);
	localparam int TIME_W      = 32;
	localparam int CFG_W       = 16;
	localparam int CFG_IDX_W   = 1;

	localparam logic [ENT_W-1:0] ENC_ENT = ENT_W'(NUM_BUTTONS);

	typedef enum logic [1:0] {
		ACT_PRESS     = 2'd0,
		ACT_CHECK     = 2'd1,
		ACT_ENC_PRESS = 2'd2,
		ACT_ENC_CHECK = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		MODE_SINGLE = 2'd0,
		MODE_DOUBLE = 2'd1,
		MODE_TRIPLE = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		KIND_NONE   = 2'd0,
		KIND_SINGLE = 2'd1,
		KIND_DOUBLE = 2'd2,
		KIND_TRIPLE = 2'd3
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DEAD_TIME  = 1'd0,
		CFG_DBL_WINDOW = 1'd1
	} cfg_idx_t;

	localparam logic [1:0] SRC_ENCODER = 2'd3;
	localparam logic [CFG_W-1:0] DEAD_TIME_RST  = 16'd50;
	localparam logic [CFG_W-1:0] DBL_WINDOW_RST = 16'd400;

	// press history of one source; zero means no press
	typedef struct packed {
		logic [TIME_W-1:0] newest;
		logic [TIME_W-1:0] second;
		logic [TIME_W-1:0] third;
	} hist_t;

	// write-back request to the history store
	typedef struct packed {
		logic             en;
		logic [ENT_W-1:0] addr;
		hist_t            data;
	} hist_wr_t;

endpackage

// File: rtl/mcc_evt_if.sv
interface mcc_evt_if;
	import mcc_pkg::*;

	logic              valid;
	logic              ready;
	action_t           action;
	logic [1:0]        button;
	logic [TIME_W-1:0] now_ms;
	logic [1:0]        click_mode;

	modport source (output valid, output action, output button, output now_ms,
		output click_mode, input ready);
	modport sink (input valid, input action, input button, input now_ms,
		input click_mode, output ready);
endinterface

// File: rtl/mcc_res_if.sv
interface mcc_res_if;
	import mcc_pkg::*;

	logic       valid;
	logic       ready;
	logic [1:0] clicked_source;
	kind_t      click_kind;

	modport source (output valid, output clicked_source, output click_kind, input ready);
	modport sink (input valid, input clicked_source, input click_kind, output ready);
endinterface

// File: rtl/multi_click_classifier.sv
// Multi-click classifier: takes one event or check item per clock and returns exactly
// one result item for each through stage 1 and the output register, as the result side takes them.
// Press histories of the buttons and the encoder button sit in a small one-read,
// one-write history memory; an item reads its entry on acceptance, the decision and
// write-back are made in stage 1 as the item leaves it, and a write-first bypass lets an item on the
// same source follow directly. Rate is one item per cycle, limited only by the result
// side taking items; the history reads as empty after reset without any clearing pass.
// Configuration writes must only happen while no item is in flight.
`include "multi_click_classifier_defines.svh"

module multi_click_classifier (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [mcc_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  logic [mcc_pkg::CFG_W-1:0]         cfg_data,
	mcc_evt_if.sink                           evt,
	mcc_res_if.source                         res
);
	import mcc_pkg::*;

	logic [CFG_W-1:0]  dead_time_q;
	logic [CFG_W-1:0]  window_q;

	logic              acc;
	logic              adv;
	logic [ENT_W-1:0]  rd_addr;
	hist_t             hist_s1;
	hist_wr_t          wr_req;
	hist_wr_t          wr;

	logic              valid_s1;
	action_t           action_s1;
	logic [1:0]        button_s1;
	logic [TIME_W-1:0] now_s1;
	logic [1:0]        mode_s1;
	logic [ENT_W-1:0]  addr_s1;

	logic [1:0]        src_s1;
	kind_t             kind_s1;

	logic              out_valid_q;
	logic [1:0]        out_src_q;
	kind_t             out_kind_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dead_time_q <= DEAD_TIME_RST;
			window_q    <= DBL_WINDOW_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_DEAD_TIME:  dead_time_q <= cfg_data;
				CFG_DBL_WINDOW: window_q    <= cfg_data;
				default:        dead_time_q <= dead_time_q;
			endcase
		end
	end

	// handshake: stage 1 moves on when the output register is free or being taken
	assign adv       = !out_valid_q || res.ready;
	assign evt.ready = !valid_s1 || adv;
	assign acc       = evt.valid && evt.ready;

	// entry address for the incoming item
	always_comb begin
		if (evt.action == ACT_PRESS || evt.action == ACT_CHECK) begin
			rd_addr = ENT_W'(evt.button);
		end else begin
			rd_addr = ENC_ENT;
		end
	end

	mcc_hist_mem u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (acc),
		.rd_addr (rd_addr),
		.rd_data (hist_s1),
		.wr      (wr)
	);

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (evt.ready) begin
			valid_s1 <= evt.valid;
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (acc) begin
			action_s1 <= evt.action;
			button_s1 <= evt.button;
			now_s1    <= evt.now_ms;
			mode_s1   <= evt.click_mode;
			addr_s1   <= rd_addr;
		end
	end

	mcc_classify u_cls (
		.action                 (action_s1),
		.button                 (button_s1),
		.now_ms                 (now_s1),
		.click_mode             (mode_s1),
		.addr                   (addr_s1),
		.hist                   (hist_s1),
		.dead_time_ms           (dead_time_q),
		.double_click_window_ms (window_q),
		.wr                     (wr_req),
		.clicked_source         (src_s1),
		.click_kind             (kind_s1)
	);

	// write back only when the item leaves stage 1
	always_comb begin
		wr    = wr_req;
		wr.en = wr_req.en && valid_s1 && adv;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			out_src_q  <= src_s1;
			out_kind_q <= kind_s1;
		end
	end

	assign res.valid          = out_valid_q;
	assign res.clicked_source = out_src_q;
	assign res.click_kind     = out_kind_q;

	// checks
	`MCC_ASSERT_NEXT(a_acc_fills_s1, acc, valid_s1, "accepted item missing from stage 1")
	`MCC_ASSERT_NOW(a_no_wr_on_stall, valid_s1 && !adv, !wr.en, "history written while stalled")
	`MCC_ASSERT_NOW(a_enc_single, res.valid && res.clicked_source == SRC_ENCODER, res.click_kind == KIND_SINGLE || res.click_kind == KIND_NONE, "encoder result other than single")
	`MCC_ASSERT_NOW(a_none_src_zero, res.valid && res.click_kind == KIND_NONE, res.clicked_source == 2'd0, "source set on empty result")
endmodule

// File: rtl/mcc_hist_mem.sv
module mcc_hist_mem (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    rd_en,
	input  logic [mcc_pkg::ENT_W-1:0] rd_addr,
	output mcc_pkg::hist_t          rd_data,
	input  mcc_pkg::hist_wr_t       wr
);
	import mcc_pkg::*;

	hist_t               mem [NUM_ENT];
	logic  [NUM_ENT-1:0] valid_q;
	hist_t               rd_data_q;

	// storage array, no reset
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	// entry valid bits: an unwritten entry reads as empty
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr.en) begin
			valid_q[wr.addr] <= 1'b1;
		end
	end

	// registered read, write-first when the same entry is written this cycle
	always_ff @(posedge clk) begin
		if (rd_en) begin
			if (wr.en && wr.addr == rd_addr) begin
				rd_data_q <= wr.data;
			end else if (valid_q[rd_addr]) begin
				rd_data_q <= mem[rd_addr];
			end else begin
				rd_data_q <= '0;
			end
		end
	end

	assign rd_data = rd_data_q;
endmodule

// File: rtl/mcc_classify.sv
module mcc_classify (
	input  mcc_pkg::action_t              action,
	input  logic [1:0]                    button,
	input  logic [mcc_pkg::TIME_W-1:0]    now_ms,
	input  logic [1:0]                    click_mode,
	input  logic [mcc_pkg::ENT_W-1:0]     addr,
	input  mcc_pkg::hist_t                hist,
	input  logic [mcc_pkg::CFG_W-1:0]     dead_time_ms,
	input  logic [mcc_pkg::CFG_W-1:0]     double_click_window_ms,
	output mcc_pkg::hist_wr_t             wr,
	output logic [1:0]                    clicked_source,
	output mcc_pkg::kind_t                click_kind
);
	import mcc_pkg::*;

	logic              btn_ok;
	logic [TIME_W-1:0] age;
	logic [TIME_W-1:0] age2;
	logic [TIME_W-1:0] age3;
	logic [TIME_W-1:0] dead_ext;
	logic [TIME_W-1:0] win_ext;
	logic [TIME_W-1:0] win2;
	logic [TIME_W-1:0] win3;
	logic              past_dead;
	logic              multi;
	logic              is_double;
	logic              is_triple;

	always_comb begin
		btn_ok    = 32'(button) < NUM_BUTTONS;
		age       = now_ms - hist.newest;
		age2      = now_ms - hist.second;
		age3      = now_ms - hist.third;
		dead_ext  = TIME_W'(dead_time_ms);
		win_ext   = TIME_W'(double_click_window_ms);
		// 2W and 3W fit easily, window is only 16 bits
		win2      = win_ext << 1;
		win3      = win2 + win_ext;
		past_dead = hist.newest != '0 && age > dead_ext;
		multi     = click_mode == MODE_DOUBLE || click_mode == MODE_TRIPLE;
		is_double = hist.second != '0 && age2 < win2;
		is_triple = click_mode == MODE_TRIPLE && hist.third != '0 && age3 < win3;

		wr.en          = 1'b0;
		wr.addr        = addr;
		wr.data        = '0;
		clicked_source = 2'd0;
		click_kind     = KIND_NONE;

		unique case (action)
			ACT_PRESS: begin
				// press outside the dead time shifts the history
				if (btn_ok && (hist.newest == '0 || age > dead_ext)) begin
					wr.en          = 1'b1;
					wr.data.newest = now_ms;
					wr.data.second = hist.newest;
					wr.data.third  = hist.second;
				end
			end
			ACT_CHECK: begin
				if (btn_ok && past_dead && !(multi && age <= win_ext)) begin
					wr.en          = 1'b1;
					clicked_source = button;
					if (multi && is_double) begin
						click_kind = is_triple ? KIND_TRIPLE : KIND_DOUBLE;
					end else begin
						click_kind = KIND_SINGLE;
					end
				end
			end
			ACT_ENC_PRESS: begin
				wr.en          = 1'b1;
				wr.data.newest = now_ms;
			end
			ACT_ENC_CHECK: begin
				if (past_dead) begin
					wr.en          = 1'b1;
					clicked_source = SRC_ENCODER;
					click_kind     = KIND_SINGLE;
				end
			end
			default: begin
				wr.en = 1'b0;
			end
		endcase
	end
endmodule
